### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear probing key/value table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   // field widths fixed by the request and response words
   localparam int KEY_W     = 31;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int VAL_IO_W  = 32;

   // request op codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [VAL_IO_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_IO_W-1:0] value_out;
   } rsp_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE
   } state_type;

endpackage

### rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/lpht_home.sv
// ----------------------------------------------------------------------------
// lpht_home
// Home slot unit: key modulo table size by reciprocal multiplication, a
// quotient estimate step and then a remainder step.
// ----------------------------------------------------------------------------
module lpht_home
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [KEY_W-1:0]              key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] home_slot
);

   localparam int SLOT_W  = $clog2(TABLE_SIZE);
   localparam int RECIP_W = 32;
   localparam int PROD_W  = KEY_W + RECIP_W;
   localparam int SHIFT   = KEY_W + SLOT_W;
   localparam int QUO_W   = PROD_W - SHIFT;
   // ceil(2^SHIFT / TABLE_SIZE) gives an exact quotient for every key
   localparam logic [63:0] RECIP_NUM = 64'd1 << SHIFT;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((RECIP_NUM + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
   localparam logic [SLOT_W:0] SIZE_V = (SLOT_W+1)'(TABLE_SIZE);

   logic              mul_ff;
   logic              sub_ff;
   logic              done_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [QUO_W-1:0]  quo_in;
   logic [SLOT_W-1:0] rem_ff;
   logic [SLOT_W-1:0] rem_in;
   logic [PROD_W-1:0] prod;
   logic [SLOT_W-1:0] quo_size;

   // quotient from the reciprocal, remainder from the low bits
   always_comb begin
      prod     = PROD_W'(key_ff) * PROD_W'(RECIP);
      quo_in   = prod[PROD_W-1 -: QUO_W];
      quo_size = SLOT_W'(quo_ff * SIZE_V);
      rem_in   = key_ff[SLOT_W-1:0] - quo_size;
   end

   // step control: multiply, then subtract, then done
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= go;
         sub_ff  <= mul_ff;
         done_ff <= sub_ff;
      end
   end

   // key, quotient and remainder
   always_ff @(posedge clock) begin
      if (go) begin
         key_ff <= key;
      end
      if (mul_ff) begin
         quo_ff <= quo_in;
      end
      if (sub_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign home_slot = rem_ff;

endmodule

### rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Fixed size key/value table with linear probing: insert, lookup, remove.
// ----------------------------------------------------------------------------
// a request goes through the reciprocal multiply home slot unit, then probes
//   n slots (1 to TABLE_SIZE) before the result strobe
// unused op codes answer not found with a strobe in the cycle after accept
// one probe per cycle through the single table RAM read port; busy meanwhile
// after reset a clearing pass over all TABLE_SIZE slots runs with busy high
// results cannot be stalled: rsp_valid is high for exactly one cycle
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE  = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   localparam int SLOT_W = $clog2(TABLE_SIZE);
   localparam int CNT_W  = SLOT_W + 1;
   localparam int ENT_W  = 1 + KEY_W + VALUE_WIDTH;

   state_type            state_ff;
   state_type            state_in;
   logic [SLOT_W-1:0]    clr_ff;
   logic [OP_W-1:0]      op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [SLOT_W-1:0]    issue_ff;
   logic [SLOT_W-1:0]    issue_in;
   logic [SLOT_W-1:0]    chk_slot_ff;
   logic [CNT_W-1:0]     chk_cnt_ff;
   logic                 rd_pend_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_word_ff;

   logic                 op_ok;
   logic                 hash_go;
   logic                 hash_done;
   logic [SLOT_W-1:0]    home_slot;

   logic                 ram_we;
   logic [SLOT_W-1:0]    ram_waddr;
   logic [ENT_W-1:0]     ram_wdata;
   logic [SLOT_W-1:0]    ram_raddr;
   logic [ENT_W-1:0]     ram_rdata;

   logic                 ent_valid;
   logic [KEY_W-1:0]     ent_key;
   logic [VALUE_WIDTH-1:0] ent_val;
   logic                 key_hit;
   logic                 last_chk;

   logic                 fin;
   logic [STATUS_W-1:0]  fin_status;
   logic [VAL_IO_W-1:0]  fin_value;

   // request decode
   assign op_ok   = (req_word.op == OP_INSERT) || (req_word.op == OP_LOOKUP)
                 || (req_word.op == OP_REMOVE);
   assign hash_go = (state_ff == S_IDLE) && start && op_ok;

   lpht_home #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_home (
      .clock     (clock),
      .reset     (reset),
      .go        (hash_go),
      .key       (req_word.key),
      .done      (hash_done),
      .home_slot (home_slot)
   );

   lpht_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // entry fields of the slot under check
   assign ent_valid = ram_rdata[ENT_W-1];
   assign ent_key   = ram_rdata[ENT_W-2 -: KEY_W];
   assign ent_val   = ram_rdata[VALUE_WIDTH-1:0];
   assign key_hit   = ent_valid && (ent_key == key_ff);
   assign last_chk  = (chk_cnt_ff == CNT_W'(TABLE_SIZE-1));

   // next probe slot with wrap
   assign issue_in = (issue_ff == SLOT_W'(TABLE_SIZE-1)) ? '0 : issue_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == SLOT_W'(TABLE_SIZE-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (hash_go) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (fin) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: table access and probe outcome
   always_comb begin
      busy       = 1'b1;
      ram_we     = 1'b0;
      ram_waddr  = chk_slot_ff;
      ram_wdata  = {1'b0, key_ff, val_ff};
      ram_raddr  = issue_ff;
      fin        = 1'b0;
      fin_status = ST_MISS;
      fin_value  = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         S_IDLE: begin
            busy = 1'b0;
            // unused op code answers not found at once
            if (start && !op_ok) begin
               fin = 1'b1;
            end
         end
         S_HASH: begin
         end
         S_PROBE: begin
            if (rd_pend_ff) begin
               if (op_ff == OP_INSERT) begin
                  priority if (!ent_valid) begin
                     ram_we     = 1'b1;
                     ram_wdata  = {1'b1, key_ff, val_ff};
                     fin        = 1'b1;
                     fin_status = ST_OK;
                  end else if (key_hit) begin
                     fin        = 1'b1;
                     fin_status = ST_DUP;
                  end else if (last_chk) begin
                     fin        = 1'b1;
                     fin_status = ST_FULL;
                  end
               end else begin
                  // lookup or remove act on the first match from home
                  priority if (key_hit) begin
                     fin        = 1'b1;
                     fin_status = ST_OK;
                     if (op_ff == OP_LOOKUP) begin
                        fin_value = VAL_IO_W'(ent_val);
                     end else begin
                        ram_we = 1'b1;
                     end
                  end else if (last_chk) begin
                     fin        = 1'b1;
                     fin_status = ST_MISS;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (hash_done) begin
            rd_pend_ff <= 1'b0;
         end else if (state_ff == S_PROBE) begin
            rd_pend_ff <= 1'b1;
         end
      end
   end

   // request word capture and probe pointers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff  <= req_word.op;
         key_ff <= req_word.key;
         val_ff <= VALUE_WIDTH'(req_word.value_in);
      end
      if (hash_done) begin
         issue_ff   <= home_slot;
         chk_cnt_ff <= '0;
      end else if (state_ff == S_PROBE) begin
         issue_ff    <= issue_in;
         chk_slot_ff <= issue_ff;
         if (rd_pend_ff) begin
            chk_cnt_ff <= chk_cnt_ff + 1'b1;
         end
      end
      if (fin) begin
         rsp_word_ff.status    <= fin_status;
         rsp_word_ff.value_out <= fin_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // home slot always lands inside the table
   a_home_range: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (home_slot <= SLOT_W'(TABLE_SIZE-1)))
      else $error("home slot out of range");

   // probe never checks more slots than the table holds
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (chk_cnt_ff <= CNT_W'(TABLE_SIZE-1)))
      else $error("probe ran past table size");

   // probe writes only once a slot word has come back
   a_probe_write: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_PROBE) |-> (rd_pend_ff && fin))
      else $error("table write without checked slot");

   // table writes only in clearing pass or probe
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_PROBE))
      else $error("table write in wrong state");

   // table full only answers an insert
   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_FULL) |-> (op_ff == OP_INSERT))
      else $error("table full on non-insert word");

endmodule

### verif/linear_probe_hash_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Drives insert, lookup and remove words into the probing table, keeps its
// own copy of the slot contents to predict each response word, and checks
// every response in order. Covers wrap-around probing, duplicates, holes left
// by remove, a completely full table, unused op codes and random traffic.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;
   import lpht_pkg::*;

   localparam int SLOTS = 256;
   // op code with no operation behind it
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // worst case quiet stretch: a full scan of all slots plus the longest sender gap
   localparam int QUIET_LIMIT = 4000;
   // a full scan plus margin
   localparam int SETTLE_CYCLES = 300;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_word  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;

   // predicted table contents
   bit                  tbl_used [SLOTS];
   logic [KEY_W-1:0]    tbl_key  [SLOTS];
   logic [VAL_IO_W-1:0] tbl_val  [SLOTS];

   rsp_type pending_rsp [$];
   int      error_count = 0;
   int      idle_pct    = 0;
   int      quiet_count = 0;

   linear_probe_hash_table #(
      .TABLE_SIZE  (SLOTS),
      .VALUE_WIDTH (VAL_IO_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #6 clock = ~clock;

   // number of occupied slots in the predicted table
   function automatic int table_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += tbl_used[i];
      return n;
   endfunction

   // first occupied slot holding the key, SLOTS if none
   function automatic int find_slot(logic [KEY_W-1:0] key);
      int s;
      s = key % SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_used[s] && tbl_key[s] == key) return s;
         s = (s + 1) % SLOTS;
      end
      return SLOTS;
   endfunction

   // apply one request word to the predicted table and return its response
   function automatic rsp_type predict_response(req_type w);
      rsp_type r;
      int      s;
      r.status    = ST_MISS;
      r.value_out = '0;
      case (w.op)
         OP_INSERT: begin
            r.status = ST_FULL;
            s = w.key % SLOTS;
            for (int i = 0; i < SLOTS; i++) begin
               if (!tbl_used[s]) begin
                  tbl_used[s] = 1'b1;
                  tbl_key[s]  = w.key;
                  tbl_val[s]  = w.value_in;
                  r.status    = ST_OK;
                  break;
               end
               if (tbl_key[s] == w.key) begin
                  r.status = ST_DUP;
                  break;
               end
               s = (s + 1) % SLOTS;
            end
         end
         OP_LOOKUP: begin
            s = find_slot(w.key);
            if (s < SLOTS) begin
               r.status    = ST_OK;
               r.value_out = tbl_val[s];
            end
         end
         OP_REMOVE: begin
            s = find_slot(w.key);
            if (s < SLOTS) begin
               tbl_used[s] = 1'b0;
               r.status    = ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // send one request word, record its prediction, then maybe idle
   task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [VAL_IO_W-1:0] value);
      req_type w;
      int      gap;
      w.op       = op;
      w.key      = key;
      w.value_in = value;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp.push_back(predict_response(w));
      gap = 0;
      if ($urandom_range(99) < idle_pct)
         gap = ($urandom_range(3) == 0) ? $urandom_range(9, 320) : $urandom_range(1, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every predicted response has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // key of a random occupied slot, or a random key if the table is empty
   function automatic logic [KEY_W-1:0] stored_key();
      int s;
      if (table_count() == 0) return KEY_W'($urandom());
      s = $urandom_range(SLOTS - 1);
      while (!tbl_used[s]) s = (s + 1) % SLOTS;
      return tbl_key[s];
   endfunction

   // mostly stored keys and keys crowding one wrapping cluster, some wide keys
   function automatic logic [KEY_W-1:0] pick_key();
      int         roll;
      logic [7:0] low;
      roll = $urandom_range(99);
      low  = 8'hF4 + 8'($urandom_range(15));
      if (roll < 50) return stored_key();
      if (roll < 85) return {(KEY_W-8)'($urandom_range(3)), low};
      return KEY_W'($urandom());
   endfunction

   // extremes, wrap at the top slot, duplicates, holes and the unused op
   task automatic directed_test();
      idle_pct = 0;
      send_word(OP_LOOKUP, 31'd0, 32'd0);
      send_word(OP_REMOVE, 31'd5, 32'd0);
      send_word(OP_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 31'd0, 32'd0);
      send_word(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 31'h0FF, 32'hA5A5_A5A5);
      send_word(OP_INSERT, 31'd0, 32'h1234_5678);
      send_word(OP_LOOKUP, 31'd0, 32'd0);
      send_word(OP_LOOKUP, 31'h7FFF_FFFF, 32'd0);
      send_word(OP_LOOKUP, 31'h0FF, 32'd0);
      send_word(OP_INSERT, 31'h100, 32'h1111_1111);
      send_word(OP_REMOVE, 31'd0, 32'hFFFF_FFFF);
      send_word(OP_LOOKUP, 31'd0, 32'd0);
      // refill the hole although the key already sits further along
      send_word(OP_INSERT, 31'h100, 32'h2222_2222);
      send_word(OP_LOOKUP, 31'h100, 32'd0);
      send_word(OP_REMOVE, 31'h100, 32'd0);
      send_word(OP_LOOKUP, 31'h100, 32'd0);
      send_word(OP_REMOVE, 31'h100, 32'd0);
      send_word(OP_REMOVE, 31'h100, 32'd0);
      send_word(OP_LOOKUP, 31'h0FF, 32'd0);
      send_word(OP_UNUSED, 31'd0, 32'd0);
      send_word(OP_INSERT, 31'h5555_5555, 32'h5555_5555);
      send_word(OP_LOOKUP, 31'h2AAA_AAAA, 32'd0);
      wait_drained();
   endtask

   // fill every slot, then hit the full table, then empty most of it
   task automatic full_table_test();
      logic [KEY_W-1:0] key;
      int               guard;
      idle_pct = 31;
      guard    = 0;
      while (table_count() < SLOTS && guard < 600) begin
         key      = KEY_W'($urandom());
         key[7:0] = guard[7:0];
         send_word(OP_INSERT, key, $urandom());
         guard++;
      end
      send_word(OP_INSERT, KEY_W'($urandom()), $urandom());
      send_word(OP_INSERT, stored_key(), $urandom());
      send_word(OP_LOOKUP, stored_key(), 32'd0);
      send_word(OP_LOOKUP, KEY_W'($urandom()), 32'd0);
      send_word(OP_REMOVE, KEY_W'($urandom()), 32'd0);
      // free one slot and refill it through a long probe
      send_word(OP_REMOVE, stored_key(), 32'd0);
      send_word(OP_INSERT, KEY_W'($urandom()), $urandom());
      send_word(OP_INSERT, KEY_W'($urandom()), $urandom());
      for (int i = 0; i < SLOTS; i++)
         if (tbl_used[i] && $urandom_range(2) != 0) send_word(OP_REMOVE, tbl_key[i], $urandom());
      wait_drained();
   endtask

   // random traffic in several idling phases, pausing for a drain after each
   task automatic random_test();
      int               phase_idle [4] = '{0, 87, 0, 31};
      int               roll;
      logic [OP_W-1:0]  op;
      foreach (phase_idle[p]) begin
         idle_pct = phase_idle[p];
         for (int n = 0; n < 170; n++) begin
            roll = $urandom_range(99);
            if (roll < 40)      op = OP_INSERT;
            else if (roll < 70) op = OP_LOOKUP;
            else if (roll < 95) op = OP_REMOVE;
            else                op = OP_UNUSED;
            if (op == OP_INSERT && table_count() > 230) op = OP_REMOVE;
            send_word(op, pick_key(), $urandom());
            if ($urandom_range(39) == 0) wait_drained();
         end
         wait_drained();
      end
   endtask

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request pending: status %0d value_out %08h",
                   rsp_word.status, rsp_word.value_out);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.value_out !== want.value_out) begin
               $error("value_out: expected %08h, actual %08h",
                      want.value_out, rsp_word.value_out);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with neither an accepted request nor a response
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      directed_test();
      full_table_test();
      random_test();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
